>>> rtl/batch_record_stream_decoder_assert.svh
// ----------------------------------------------------------------------------
// batch record stream decoder assertion macros
// concurrent assertion shorthands used by the checker file
// ----------------------------------------------------------------------------
`ifndef BATCH_RECORD_STREAM_DECODER_ASSERT_SVH
`define BATCH_RECORD_STREAM_DECODER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define BRSD_ASSERT_IMPL(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> cons) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define BRSD_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> cons) \
    else $error(msg);

`endif

>>> rtl/brsd_pkg.sv
// ----------------------------------------------------------------------------
// brsd_pkg
// shared types and constants of the batch record stream decoder
// ----------------------------------------------------------------------------
package brsd_pkg;

  localparam int HEADER_BYTES = 9;
  localparam int HDR_IDX_W    = 4;
  localparam logic [HDR_IDX_W-1:0] LAST_HDR_IDX = HDR_IDX_W'(HEADER_BYTES - 1);
  localparam logic [HDR_IDX_W-1:0] LAST_KEY_IDX = HDR_IDX_W'(4);

  // configuration port
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 8;
  localparam logic [CFG_INDEX_W-1:0] CFG_PUT_CODE    = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_DELETE_CODE = 1'b1;
  localparam logic [7:0] PUT_CODE_RESET    = 8'd1;
  localparam logic [7:0] DELETE_CODE_RESET = 8'd0;

  // result queue
  localparam int RQ_DEPTH = 8;
  localparam int RQ_PTR_W = $clog2(RQ_DEPTH);
  localparam int RQ_CNT_W = $clog2(RQ_DEPTH + 1);
  // room for two results in the input register and two from the next request
  localparam logic [RQ_CNT_W-1:0] RQ_TAKE_LIMIT = RQ_CNT_W'(RQ_DEPTH - 4);

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_KEY    = 2'd1,
    KIND_VALUE  = 2'd2,
    KIND_STATUS = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK            = 3'd0,
    ST_SHORT_HEADER  = 3'd1,
    ST_BAD_TYPE      = 3'd2,
    ST_SHORT_PAYLOAD = 3'd3,
    ST_DELETE_VALUE  = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1
  } phase_t;

  typedef struct packed {
    kind_t       kind;
    logic        is_delete;
    logic [31:0] key_length;
    logic [31:0] value_length;
    logic [7:0]  payload_byte;
    status_t     status;
    logic        last;
  } result_t;

  // up to two results written to the queue in one cycle, packed from slot0
  typedef struct packed {
    logic [1:0] num;
    result_t    slot0;
    result_t    slot1;
  } push_t;

endpackage

>>> rtl/brsd_stream_if.sv
// ----------------------------------------------------------------------------
// brsd stream interfaces
// valid/ready channels for input bytes and decoded results
// ----------------------------------------------------------------------------
interface brsd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_batch;

  modport source (output valid, output data_byte, output end_of_batch, input ready);
  modport sink   (input valid, input data_byte, input end_of_batch, output ready);
endinterface

interface brsd_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic        is_delete;
  logic [31:0] key_length;
  logic [31:0] value_length;
  logic [7:0]  payload_byte;
  logic [2:0]  status;
  logic        last;

  modport source (output valid, output kind, output is_delete, output key_length,
                  output value_length, output payload_byte, output status,
                  output last, input ready);
  modport sink   (input valid, input kind, input is_delete, input key_length,
                  input value_length, input payload_byte, input status,
                  input last, output ready);
endinterface

>>> rtl/batch_record_stream_decoder.sv
// ----------------------------------------------------------------------------
// batch_record_stream_decoder
// byte-wide parser for batches of length-prefixed key/value records
// ----------------------------------------------------------------------------
// byte_in carries the encoded batch one byte a request, end_of_batch marking
// the final byte. result_out gives a header result per well-typed record, one
// result per key or value byte, and a status result with last set on the
// final byte of the batch.
// put and delete type codes are written on the cfg port while idle: the user
// must keep to this, as the block does not enforce it.
// a result passes through the input register, then the result queue, before
// it is offered on result_out.
// throughput: one byte per cycle while byte_in.ready is high; the final byte
// of a batch yields up to two results, which leave the queue one at a time.
// byte_in.ready is set by the fill of the eight-entry result queue: it drops
// while more than four results wait, so a stalled receiver stops the input
// and no result is lost.
// reset empties the queue, returns the parser to the start of a batch and
// sets put code 1, delete code 0.
// ----------------------------------------------------------------------------
module batch_record_stream_decoder (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [brsd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [brsd_pkg::CFG_DATA_W-1:0]  cfg_data,
  brsd_byte_if.sink                        byte_in,
  brsd_result_if.source                    result_out
);

  logic              can_take;
  logic              take;
  brsd_pkg::push_t   push;
  brsd_pkg::result_t head;

  assign byte_in.ready = can_take;
  assign take          = byte_in.valid && can_take;

  brsd_decode u_decode (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .take         (take),
    .data_byte    (byte_in.data_byte),
    .end_of_batch (byte_in.end_of_batch),
    .push         (push)
  );

  brsd_result_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .can_take  (can_take),
    .head      (head),
    .out_valid (result_out.valid),
    .out_ready (result_out.ready)
  );

  assign result_out.kind         = head.kind;
  assign result_out.is_delete    = head.is_delete;
  assign result_out.key_length   = head.key_length;
  assign result_out.value_length = head.value_length;
  assign result_out.payload_byte = head.payload_byte;
  assign result_out.status       = head.status;
  assign result_out.last         = head.last;

endmodule

>>> rtl/brsd_decode.sv
// ----------------------------------------------------------------------------
// brsd_decode
// input register, record parser state and result generation
// ----------------------------------------------------------------------------
module brsd_decode (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [brsd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [brsd_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             take,
  input  logic [7:0]                       data_byte,
  input  logic                             end_of_batch,
  output brsd_pkg::push_t                  push
);

  logic       stage_valid;
  logic [7:0] stage_byte;
  logic       stage_eob;

  logic [7:0] put_code;
  logic [7:0] delete_code;

  brsd_pkg::phase_t                phase, phase_next;
  logic [brsd_pkg::HDR_IDX_W-1:0]  header_index, header_index_next;
  logic [7:0]                      type_byte, type_byte_next;
  logic [31:0]                     key_len, key_len_next;
  logic [31:0]                     val_len, val_len_next;
  logic [32:0]                     bytes_left, bytes_left_next;
  brsd_pkg::status_t               error_code, error_code_next;
  logic                            delete_value_flag, delete_value_flag_next;

  logic                  is_put, is_del;
  logic [1:0]            lane;
  logic                  body_valid;
  brsd_pkg::result_t     body, stat;
  brsd_pkg::status_t     st;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else begin
      stage_valid <= take;
    end
    if (take) begin
      stage_byte <= data_byte;
      stage_eob  <= end_of_batch;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      put_code    <= brsd_pkg::PUT_CODE_RESET;
      delete_code <= brsd_pkg::DELETE_CODE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        brsd_pkg::CFG_PUT_CODE:    put_code    <= cfg_data;
        brsd_pkg::CFG_DELETE_CODE: delete_code <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= brsd_pkg::PH_HEADER;
      header_index      <= '0;
      type_byte         <= '0;
      key_len           <= '0;
      val_len           <= '0;
      bytes_left        <= '0;
      error_code        <= brsd_pkg::ST_OK;
      delete_value_flag <= 1'b0;
    end else begin
      phase             <= phase_next;
      header_index      <= header_index_next;
      type_byte         <= type_byte_next;
      key_len           <= key_len_next;
      val_len           <= val_len_next;
      bytes_left        <= bytes_left_next;
      error_code        <= error_code_next;
      delete_value_flag <= delete_value_flag_next;
    end
  end

  always_comb begin
    phase_next             = phase;
    header_index_next      = header_index;
    type_byte_next         = type_byte;
    key_len_next           = key_len;
    val_len_next           = val_len;
    bytes_left_next        = bytes_left;
    error_code_next        = error_code;
    delete_value_flag_next = delete_value_flag;
    is_put     = 1'b0;
    is_del     = 1'b0;
    lane       = 2'(header_index - brsd_pkg::HDR_IDX_W'(1));
    body_valid = 1'b0;
    body       = '0;
    stat       = '0;
    st         = brsd_pkg::ST_OK;
    push       = '0;

    if (stage_valid) begin
      if (error_code == brsd_pkg::ST_OK) begin
        if (phase == brsd_pkg::PH_HEADER) begin
          if (header_index == '0) begin
            type_byte_next = stage_byte;
            key_len_next   = '0;
            val_len_next   = '0;
          end else if (header_index <= brsd_pkg::LAST_KEY_IDX) begin
            key_len_next[{lane, 3'b000} +: 8] = stage_byte;
          end else begin
            val_len_next[{lane, 3'b000} +: 8] = stage_byte;
          end

          if (header_index == brsd_pkg::LAST_HDR_IDX) begin
            is_put = (type_byte == put_code);
            is_del = !is_put && (type_byte == delete_code);
            header_index_next = '0;
            if (!is_put && !is_del) begin
              error_code_next = brsd_pkg::ST_BAD_TYPE;
            end else begin
              body_valid        = 1'b1;
              body.kind         = brsd_pkg::KIND_HEADER;
              body.is_delete    = is_del;
              body.key_length   = key_len_next;
              body.value_length = val_len_next;
              delete_value_flag_next = is_del && (val_len_next != '0);
              bytes_left_next = {1'b0, key_len_next} + {1'b0, val_len_next};
              if (bytes_left_next != '0) begin
                phase_next = brsd_pkg::PH_PAYLOAD;
              end
            end
          end else begin
            header_index_next = header_index + brsd_pkg::HDR_IDX_W'(1);
          end
        end else begin
          body_valid        = 1'b1;
          body.kind         = (bytes_left > {1'b0, val_len}) ? brsd_pkg::KIND_KEY
                                                             : brsd_pkg::KIND_VALUE;
          body.payload_byte = stage_byte;
          bytes_left_next   = bytes_left - 33'd1;
          if (bytes_left_next == '0) begin
            phase_next = brsd_pkg::PH_HEADER;
            if (delete_value_flag) begin
              error_code_next = brsd_pkg::ST_DELETE_VALUE;
            end
          end
        end
      end

      if (stage_eob) begin
        priority if (error_code_next != brsd_pkg::ST_OK) begin
          st = error_code_next;
        end else if (phase_next == brsd_pkg::PH_PAYLOAD) begin
          st = brsd_pkg::ST_SHORT_PAYLOAD;
        end else if (header_index_next != '0) begin
          st = brsd_pkg::ST_SHORT_HEADER;
        end else begin
          st = brsd_pkg::ST_OK;
        end
        stat.kind   = brsd_pkg::KIND_STATUS;
        stat.status = st;
        stat.last   = 1'b1;

        // batch done: back to the reset state, codes kept
        phase_next             = brsd_pkg::PH_HEADER;
        header_index_next      = '0;
        type_byte_next         = '0;
        key_len_next           = '0;
        val_len_next           = '0;
        bytes_left_next        = '0;
        error_code_next        = brsd_pkg::ST_OK;
        delete_value_flag_next = 1'b0;
      end

      if (body_valid) begin
        push.slot0 = body;
        push.slot1 = stat;
        push.num   = stage_eob ? 2'd2 : 2'd1;
      end else begin
        push.slot0 = stat;
        push.num   = stage_eob ? 2'd1 : 2'd0;
      end
    end
  end

endmodule

>>> rtl/brsd_result_fifo.sv
// ----------------------------------------------------------------------------
// brsd_result_fifo
// result queue taking up to two results a cycle, one out a cycle while out_ready is high
// ----------------------------------------------------------------------------
module brsd_result_fifo (
  input  logic              clk,
  input  logic              rst,
  input  brsd_pkg::push_t   push,
  output logic              can_take,
  output brsd_pkg::result_t head,
  output logic              out_valid,
  input  logic              out_ready
);

  brsd_pkg::result_t mem [brsd_pkg::RQ_DEPTH];

  logic [brsd_pkg::RQ_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [brsd_pkg::RQ_CNT_W-1:0] count;
  logic                          pop;

  assign out_valid = (count != '0);
  assign pop       = out_valid && out_ready;
  assign head      = mem[rd_ptr];
  assign can_take  = (count <= brsd_pkg::RQ_TAKE_LIMIT);

  always_ff @(posedge clk) begin
    if (push.num != 2'd0) begin
      mem[wr_ptr] <= push.slot0;
    end
    if (push.num == 2'd2) begin
      mem[wr_ptr + brsd_pkg::RQ_PTR_W'(1)] <= push.slot1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + brsd_pkg::RQ_PTR_W'(push.num);
      rd_ptr <= rd_ptr + brsd_pkg::RQ_PTR_W'(pop);
      count  <= count + brsd_pkg::RQ_CNT_W'(push.num) - brsd_pkg::RQ_CNT_W'(pop);
    end
  end

endmodule

>>> rtl/brsd_checker.sv
// ----------------------------------------------------------------------------
// brsd_checker
// port-level checks of the batch record stream decoder
// ----------------------------------------------------------------------------
`include "batch_record_stream_decoder_assert.svh"

module brsd_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic in_eob,
  input logic out_valid,
  input logic out_ready
);

  // a stalled result stays offered
  `BRSD_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid, "result dropped while stalled")

  // nothing waiting means room for a new request
  `BRSD_ASSERT_IMPL(a_empty_ready, clk, rst, !out_valid, in_ready, "input blocked with an empty queue")

  // final byte always gives a status result through the input register and result queue
  `BRSD_ASSERT_IMPL(a_eob_result, clk, rst, in_valid && in_ready && in_eob, ##2 out_valid, "no result after final byte")

endmodule

bind batch_record_stream_decoder brsd_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (byte_in.valid),
  .in_ready  (byte_in.ready),
  .in_eob    (byte_in.end_of_batch),
  .out_valid (result_out.valid),
  .out_ready (result_out.ready)
);
